// File: hdl/ifmt_pkg.sv
package ifmt_pkg;

  localparam int unsigned MaxFieldDefault = 64;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned BcdDigits  = 20;
  localparam int unsigned BufDigits  = 22;

  localparam logic [2:0] CONV_SDEC  = 3'd0;
  localparam logic [2:0] CONV_UDEC  = 3'd1;
  localparam logic [2:0] CONV_OCT   = 3'd2;
  localparam logic [2:0] CONV_HEXL  = 3'd3;
  localparam logic [2:0] CONV_HEXU  = 3'd4;
  localparam logic [2:0] CONV_PTR   = 3'd5;
  localparam logic [2:0] CONV_RSVD6 = 3'd6;
  localparam logic [2:0] CONV_RSVD7 = 3'd7;

  localparam logic [2:0] LEN_INT     = 3'd0;
  localparam logic [2:0] LEN_CHAR    = 3'd1;
  localparam logic [2:0] LEN_SHORT   = 3'd2;
  localparam logic [2:0] LEN_LONG    = 3'd3;
  localparam logic [2:0] LEN_LLONG   = 3'd4;
  localparam logic [2:0] LEN_INTMAX  = 3'd5;
  localparam logic [2:0] LEN_SIZE    = 3'd6;
  localparam logic [2:0] LEN_PTRDIFF = 3'd7;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_LX    = 7'h78;
  localparam logic [6:0] CH_UX    = 7'h58;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {3'd0, d};
    end else if (upper) begin
      r = 7'h41 + {3'd0, d - 4'd10};
    end else begin
      r = 7'h61 + {3'd0, d - 4'd10};
    end
    return r;
  endfunction

  function automatic logic [6:0] nil_char(input logic [4:0] left);
    logic [6:0] r;
    case (left)
      5'd5:    r = 7'h28;
      5'd4:    r = 7'h6E;
      5'd3:    r = 7'h69;
      5'd2:    r = 7'h6C;
      default: r = 7'h29;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/ifmt_bcd.sv
module ifmt_bcd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [79:0] bcd_o
);

  logic [63:0] sh_q, sh_d;
  logic [79:0] bcd_q, bcd_d, adj;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;

  always_comb begin
    for (int i = 0; i < ifmt_pkg::BcdDigits; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_o = 1'b0;
    if (start_i) begin
      sh_d  = value_i;
      bcd_d = '0;
      cnt_d = 7'd64;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[78:0], sh_q[63]};
      sh_d  = {sh_q[62:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        run_d  = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign bcd_o = bcd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

endmodule

// File: hdl/integer_field_formatter_top.sv
// Formats one integer conversion request into ASCII characters, one per output
// transfer, with last_char_o on the final character. A request is taken only
// while in_stall_o is low. Decimal requests first pass through a bit-serial
// binary-to-BCD converter; every request then skips leading zero digits and
// passes a setup state, after which one character leaves per cycle while
// out_stall_i does not hold the output. Conversion codes six and seven are
// accepted and produce nothing.
module integer_field_formatter_top #(
  parameter int unsigned MAX_FIELD = ifmt_pkg::MaxFieldDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  input  logic [2:0]  conversion_i,
  input  logic [2:0]  length_mod_i,
  input  logic        left_justify_i,
  input  logic        zero_pad_i,
  input  logic        alt_form_i,
  input  logic [6:0]  field_width_i,
  input  logic        has_precision_i,
  input  logic [5:0]  precision_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  character_o,
  output logic        last_char_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [6:0] WMax = 7'(MAX_FIELD);
  localparam logic [5:0] PMax = 6'(MAX_FIELD - 2);

  logic [2:0]  state_q, state_d;
  logic [2:0]  conv_q;
  logic        left_q, zpad_q, alt_q, neg_q, nil_q, zero_q;
  logic [6:0]  w_q;
  logic [5:0]  p_q;
  logic [87:0] buf_q, buf_d;
  logic [4:0]  len_q, len_d;

  logic [6:0]  lead_q, zp_q, trail_q, tot_q;
  logic [5:0]  fill_q;
  logic [1:0]  pre_q;
  logic [13:0] pfx_q;

  logic        ov_q;
  logic [6:0]  ch_q;
  logic        last_q;

  logic        accept, load;
  logic [63:0] ext, mag;
  logic [65:0] oct_src;
  logic [87:0] oct_buf;
  logic        bcd_done;
  logic [79:0] bcd;

  logic [4:0]  s_len;
  logic [1:0]  s_plen;
  logic [5:0]  s_fill;
  logic [6:0]  s_used, s_pad;
  logic [13:0] s_pfx;
  logic        emit;
  logic [6:0]  e_ch;

  assign accept     = in_valid_i && !in_stall_o;
  assign load       = accept && (conversion_i <= ifmt_pkg::CONV_PTR);
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    ext = value_i;
    if (conversion_i != ifmt_pkg::CONV_PTR) begin
      case (length_mod_i)
        ifmt_pkg::LEN_INT: begin
          ext = {32'd0, value_i[31:0]};
          if (conversion_i == ifmt_pkg::CONV_SDEC) ext[63:32] = {32{value_i[31]}};
        end
        ifmt_pkg::LEN_CHAR: begin
          ext = {56'd0, value_i[7:0]};
          if (conversion_i == ifmt_pkg::CONV_SDEC) ext[63:8] = {56{value_i[7]}};
        end
        ifmt_pkg::LEN_SHORT: begin
          ext = {48'd0, value_i[15:0]};
          if (conversion_i == ifmt_pkg::CONV_SDEC) ext[63:16] = {48{value_i[15]}};
        end
        default: ext = value_i;
      endcase
    end
    mag = (conversion_i == ifmt_pkg::CONV_SDEC && ext[63]) ? (~ext + 64'd1) : ext;
    oct_src = {2'b00, mag};
    for (int i = 0; i < ifmt_pkg::BufDigits; i++) begin
      oct_buf[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
    end
  end

  ifmt_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load && conversion_i <= ifmt_pkg::CONV_UDEC),
    .value_i (mag),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  always_comb begin
    s_len  = nil_q ? 5'd5 : len_q;
    s_plen = 2'd0;
    s_pfx  = '0;
    if (!nil_q) begin
      if (neg_q) begin
        s_plen = 2'd1;
        s_pfx  = {ifmt_pkg::CH_MINUS, 7'd0};
      end else if (conv_q == ifmt_pkg::CONV_OCT && alt_q && !zero_q) begin
        s_plen = 2'd1;
        s_pfx  = {ifmt_pkg::CH_ZERO, 7'd0};
      end else if (conv_q == ifmt_pkg::CONV_PTR ||
                   ((conv_q == ifmt_pkg::CONV_HEXL || conv_q == ifmt_pkg::CONV_HEXU) &&
                    alt_q && !zero_q)) begin
        s_plen = 2'd2;
        s_pfx  = {ifmt_pkg::CH_ZERO,
                  (conv_q == ifmt_pkg::CONV_HEXU) ? ifmt_pkg::CH_UX : ifmt_pkg::CH_LX};
      end
    end
    s_fill = '0;
    if (!nil_q && p_q > {1'b0, s_len}) s_fill = p_q - {1'b0, s_len};
    if (conv_q == ifmt_pkg::CONV_OCT && s_plen == 2'd1 && s_fill != 6'd0)
      s_fill = s_fill - 6'd1;
    s_used = {2'd0, s_len} + {5'd0, s_plen} + {1'b0, s_fill};
    s_pad  = (w_q > s_used) ? w_q - s_used : 7'd0;
  end

  always_comb begin
    emit = (state_q == ST_EMIT) && (!ov_q || !out_stall_i);
    if (lead_q != 7'd0) begin
      e_ch = ifmt_pkg::CH_SPACE;
    end else if (pre_q != 2'd0) begin
      e_ch = pfx_q[13:7];
    end else if (zp_q != 7'd0 || fill_q != 6'd0) begin
      e_ch = ifmt_pkg::CH_ZERO;
    end else if (len_q != 5'd0) begin
      e_ch = nil_q ? ifmt_pkg::nil_char(len_q)
                   : ifmt_pkg::digit_char(buf_q[87:84], conv_q == ifmt_pkg::CONV_HEXU);
    end else begin
      e_ch = ifmt_pkg::CH_SPACE;
    end
  end

  always_comb begin
    state_d = state_q;
    buf_d   = buf_q;
    len_d   = len_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          len_d = 5'(ifmt_pkg::BufDigits);
          case (conversion_i) inside
            ifmt_pkg::CONV_SDEC, ifmt_pkg::CONV_UDEC: state_d = ST_CONV;
            ifmt_pkg::CONV_OCT: begin
              buf_d   = oct_buf;
              state_d = ST_NORM;
            end
            default: begin
              buf_d   = {24'd0, mag};
              state_d = ST_NORM;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          buf_d   = {8'd0, bcd};
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (buf_q[87:84] == 4'd0 && len_q > 5'd1) begin
          buf_d = {buf_q[83:0], 4'd0};
          len_d = len_q - 5'd1;
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        len_d   = s_len;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          if (lead_q == 7'd0 && pre_q == 2'd0 && zp_q == 7'd0 && fill_q == 6'd0 &&
              len_q != 5'd0) begin
            buf_d = {buf_q[83:0], 4'd0};
            len_d = len_q - 5'd1;
          end
          if (tot_q == 7'd1) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      tot_q   <= '0;
      lead_q  <= '0;
      pre_q   <= '0;
      zp_q    <= '0;
      fill_q  <= '0;
      trail_q <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        ov_q  <= 1'b1;
        tot_q <= tot_q - 7'd1;
        if (lead_q != 7'd0) begin
          lead_q <= lead_q - 7'd1;
        end else if (pre_q != 2'd0) begin
          pre_q <= pre_q - 2'd1;
        end else if (zp_q != 7'd0) begin
          zp_q <= zp_q - 7'd1;
        end else if (fill_q != 6'd0) begin
          fill_q <= fill_q - 6'd1;
        end else if (len_q == 5'd0) begin
          trail_q <= trail_q - 7'd1;
        end
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (state_q == ST_SETUP) begin
        lead_q  <= (!zpad_q && !left_q) ? s_pad : 7'd0;
        zp_q    <= zpad_q ? s_pad : 7'd0;
        trail_q <= left_q ? s_pad : 7'd0;
        pre_q   <= s_plen;
        fill_q  <= s_fill;
        tot_q   <= s_used + s_pad;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    len_q <= len_d;
    if (load) begin
      conv_q <= conversion_i;
      left_q <= left_justify_i;
      zpad_q <= zero_pad_i && !left_justify_i;
      alt_q  <= alt_form_i;
      neg_q  <= (conversion_i == ifmt_pkg::CONV_SDEC) && ext[63];
      nil_q  <= (conversion_i == ifmt_pkg::CONV_PTR) && (value_i == 64'd0);
      zero_q <= (mag == 64'd0);
      w_q    <= (field_width_i > WMax) ? WMax : field_width_i;
      p_q    <= !has_precision_i ? 6'd0 : ((precision_i > PMax) ? PMax : precision_i);
    end
    if (state_q == ST_SETUP) begin
      pfx_q <= s_pfx;
    end else if (emit && lead_q == 7'd0 && pre_q != 2'd0) begin
      pfx_q <= {pfx_q[6:0], 7'd0};
    end
    if (emit) begin
      ch_q   <= e_ch;
      last_q <= (tot_q == 7'd1);
    end
  end

  assign out_valid_o = ov_q;
  assign character_o = ch_q;
  assign last_char_o = last_q;

endmodule

// File: hdl/ifmt_checker.sv
module ifmt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [2:0] conversion_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] character_o,
  input logic       last_char_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o)
      && $stable(last_char_o))
    else $error("stalled output changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && conversion_i <= ifmt_pkg::CONV_PTR |=> in_stall_o)
    else $error("request accepted without going busy");

  a_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> character_o >= ifmt_pkg::CH_SPACE && character_o != 7'h7F)
    else $error("non-printable character");

  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && out_valid_o |-> last_char_o)
    else $error("idle while a field is unfinished");

endmodule

bind integer_field_formatter_top ifmt_checker u_ifmt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .conversion_i (conversion_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .character_o  (character_o),
  .last_char_o  (last_char_o)
);

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FieldMax = 64;
  localparam longint unsigned CycleLimit = 2000000;
  localparam int unsigned LongHold = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] value_i = '0;
  logic [2:0]  conversion_i = '0;
  logic [2:0]  length_mod_i = '0;
  logic        left_justify_i = 1'b0;
  logic        zero_pad_i = 1'b0;
  logic        alt_form_i = 1'b0;
  logic [6:0]  field_width_i = '0;
  logic        has_precision_i = 1'b0;
  logic [5:0]  precision_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [6:0]  character_o;
  logic        last_char_o;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } fmt_char_t;

  fmt_char_t   char_queue[$];
  int unsigned error_count = 0;
  longint unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned long_count = 0;
  int unsigned hold_cycles = 0;

  integer_field_formatter_top #(.MAX_FIELD(FieldMax)) uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void push_char(input logic [6:0] ch);
    fmt_char_t e;
    e.ch = ch;
    e.last = 1'b0;
    char_queue.push_back(e);
  endfunction

  function automatic void push_run(input logic [6:0] ch, input int unsigned count);
    for (int unsigned k = 0; k < count; k++) push_char(ch);
  endfunction

  function automatic void predict_field(input logic [63:0] raw, input logic [2:0] conv,
                                        input logic [2:0] lm, input logic left,
                                        input logic zp, input logic alt,
                                        input logic [6:0] wid, input logic hp,
                                        input logic [5:0] prec);
    logic [63:0] v, m;
    logic [6:0] dig[$];
    logic [6:0] pre[$];
    int unsigned w, p, bits, fill, pad, len, n0;
    logic zpad;
    if (conv > ifmt_pkg::CONV_PTR) return;
    n0 = char_queue.size();
    zpad = zp && !left;
    w = (wid > FieldMax) ? FieldMax : wid;
    p = (prec > FieldMax - 2) ? FieldMax - 2 : prec;
    bits = (lm == ifmt_pkg::LEN_INT) ? 32 : (lm == ifmt_pkg::LEN_CHAR) ? 8 :
           (lm == ifmt_pkg::LEN_SHORT) ? 16 : 64;
    if (conv == ifmt_pkg::CONV_PTR) bits = 64;
    v = raw;
    if (bits < 64) begin
      m = (64'd1 << bits) - 1;
      v &= m;
      if (conv == ifmt_pkg::CONV_SDEC && v[bits-1]) v |= ~m;
    end
    fill = 0;
    pad = 0;
    if (conv == ifmt_pkg::CONV_PTR && v == 0) begin
      pad = (w > 5) ? w - 5 : 0;
      if (!zpad && !left) push_run(ifmt_pkg::CH_SPACE, pad);
      if (zpad) push_run(ifmt_pkg::CH_ZERO, pad);
      for (int k = 5; k > 0; k--) push_char(ifmt_pkg::nil_char(5'(k)));
      if (left) push_run(ifmt_pkg::CH_SPACE, pad);
    end else begin
      if (conv == ifmt_pkg::CONV_SDEC && v[63]) begin
        v = ~v + 1;
        pre.push_back(ifmt_pkg::CH_MINUS);
      end
      m = v;
      do begin
        if (conv <= ifmt_pkg::CONV_UDEC) begin
          dig.push_front(ifmt_pkg::CH_ZERO + 7'(m % 10));
          m = m / 10;
        end else if (conv == ifmt_pkg::CONV_OCT) begin
          dig.push_front(ifmt_pkg::CH_ZERO + 7'(m & 7));
          m = m >> 3;
        end else begin
          dig.push_front(ifmt_pkg::digit_char(m[3:0], conv == ifmt_pkg::CONV_HEXU));
          m = m >> 4;
        end
      end while (m != 0);
      len = dig.size();
      if (conv == ifmt_pkg::CONV_OCT && alt && v != 0) begin
        pre.push_back(ifmt_pkg::CH_ZERO);
      end else if (conv == ifmt_pkg::CONV_PTR ||
                   ((conv == ifmt_pkg::CONV_HEXL || conv == ifmt_pkg::CONV_HEXU) &&
                    alt && v != 0)) begin
        pre.push_back(ifmt_pkg::CH_ZERO);
        pre.push_back((conv == ifmt_pkg::CONV_HEXU) ? ifmt_pkg::CH_UX : ifmt_pkg::CH_LX);
      end
      if (hp && p > len) fill = p - len;
      if (conv == ifmt_pkg::CONV_OCT && pre.size() == 1 && fill > 0) fill--;
      if (w > len + pre.size() + fill) pad = w - len - pre.size() - fill;
      if (!zpad && !left) push_run(ifmt_pkg::CH_SPACE, pad);
      foreach (pre[k]) push_char(pre[k]);
      if (zpad) push_run(ifmt_pkg::CH_ZERO, pad);
      push_run(ifmt_pkg::CH_ZERO, fill);
      foreach (dig[k]) push_char(dig[k]);
      if (left) push_run(ifmt_pkg::CH_SPACE, pad);
    end
    if (char_queue.size() > n0 + 64) char_queue = char_queue[0:n0+63];
    char_queue[char_queue.size()-1].last = 1'b1;
  endfunction

  task automatic send_request(input logic [63:0] raw, input logic [2:0] conv,
                              input logic [2:0] lm, input logic left, input logic zp,
                              input logic alt, input logic [6:0] wid, input logic hp,
                              input logic [5:0] prec);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    predict_field(raw, conv, lm, left, zp, alt, wid, hp, prec);
    in_valid_i <= 1'b1;
    value_i <= raw;
    conversion_i <= conv;
    length_mod_i <= lm;
    left_justify_i <= left;
    zero_pad_i <= zp;
    alt_form_i <= alt;
    field_width_i <= wid;
    has_precision_i <= hp;
    precision_i <= prec;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: v = 0;
      1: v = v >> $urandom_range(0, 63);
      2: v = ~(v >> $urandom_range(8, 63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_random(input bit wide);
    logic [6:0] wid;
    logic [5:0] prec;
    wid  = wide ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 24));
    prec = wide ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 24));
    send_request(random_value(), 3'($urandom_range(0, 5)), 3'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), wid, 1'($urandom_range(0, 1)), prec);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      out_stall_i <= 1'b0;
    end else if (long_hold && !long_hold_done) begin
      if (long_count < LongHold) begin
        long_count <= long_count + 1;
        out_stall_i <= 1'b1;
      end else begin
        long_hold_done <= 1'b1;
        out_stall_i <= 1'b0;
      end
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      hold_cycles <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    fmt_char_t exp_c;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (char_queue.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, character_o, last_char_o);
        error_count++;
      end else begin
        exp_c = char_queue.pop_front();
        if (character_o !== exp_c.ch) begin
          $display("%0t: character expected %h actual %h", $time, exp_c.ch, character_o);
          error_count++;
        end
        if (last_char_o !== exp_c.last) begin
          $display("%0t: last_char expected %b actual %b", $time, exp_c.last, last_char_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_request(64'd0, ifmt_pkg::CONV_SDEC, ifmt_pkg::LEN_INT,
                 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 6'd0);
    send_request(64'h8000_0000, ifmt_pkg::CONV_SDEC, ifmt_pkg::LEN_INT,
                 1'b0, 1'b1, 1'b0, 7'd12, 1'b0, 6'd0);
    send_request(64'h8000_0000_0000_0000, ifmt_pkg::CONV_SDEC, ifmt_pkg::LEN_LONG,
                 1'b0, 1'b0, 1'b0, 7'd0, 1'b1, 6'd25);
    send_request('1, ifmt_pkg::CONV_UDEC, ifmt_pkg::LEN_LLONG,
                 1'b1, 1'b1, 1'b0, 7'd30, 1'b0, 6'd0);
    send_request(64'hFF, ifmt_pkg::CONV_SDEC, ifmt_pkg::LEN_CHAR,
                 1'b0, 1'b0, 1'b0, 7'd6, 1'b1, 6'd4);
    send_request(64'h1_8000, ifmt_pkg::CONV_SDEC, ifmt_pkg::LEN_SHORT,
                 1'b1, 1'b0, 1'b0, 7'd9, 1'b0, 6'd0);
    send_request('1, ifmt_pkg::CONV_OCT, ifmt_pkg::LEN_INTMAX,
                 1'b0, 1'b0, 1'b1, 7'd0, 1'b1, 6'd30);
    send_request(64'd8, ifmt_pkg::CONV_OCT, ifmt_pkg::LEN_SIZE,
                 1'b0, 1'b1, 1'b1, 7'd10, 1'b1, 6'd5);
    send_request(64'd0, ifmt_pkg::CONV_OCT, ifmt_pkg::LEN_PTRDIFF,
                 1'b0, 1'b0, 1'b1, 7'd0, 1'b1, 6'd0);
    send_request(64'hDEAD_BEEF, ifmt_pkg::CONV_HEXL, ifmt_pkg::LEN_INT,
                 1'b0, 1'b1, 1'b1, 7'd14, 1'b0, 6'd0);
    send_request('1, ifmt_pkg::CONV_HEXU, ifmt_pkg::LEN_LONG,
                 1'b0, 1'b0, 1'b1, 7'd127, 1'b1, 6'd63);
    send_request(64'd0, ifmt_pkg::CONV_HEXU, ifmt_pkg::LEN_INT,
                 1'b0, 1'b0, 1'b1, 7'd3, 1'b0, 6'd0);
    send_request(64'd0, ifmt_pkg::CONV_PTR, ifmt_pkg::LEN_CHAR,
                 1'b0, 1'b0, 1'b0, 7'd9, 1'b0, 6'd0);
    send_request(64'd0, ifmt_pkg::CONV_PTR, ifmt_pkg::LEN_CHAR,
                 1'b0, 1'b1, 1'b0, 7'd9, 1'b1, 6'd20);
    send_request(64'd0, ifmt_pkg::CONV_PTR, ifmt_pkg::LEN_CHAR,
                 1'b1, 1'b1, 1'b0, 7'd9, 1'b0, 6'd0);
    send_request(64'h1234_5678_9ABC, ifmt_pkg::CONV_PTR, ifmt_pkg::LEN_CHAR,
                 1'b0, 1'b0, 1'b0, 7'd64, 1'b1, 6'd16);
    send_request('1, ifmt_pkg::CONV_RSVD6, ifmt_pkg::LEN_INT,
                 1'b0, 1'b0, 1'b0, 7'd10, 1'b0, 6'd0);
    send_request('1, ifmt_pkg::CONV_RSVD7, ifmt_pkg::LEN_INT,
                 1'b1, 1'b1, 1'b1, 7'd10, 1'b1, 6'd10);
    send_request(64'd5, ifmt_pkg::CONV_UDEC, ifmt_pkg::LEN_INT,
                 1'b1, 1'b0, 1'b0, 7'd64, 1'b1, 6'd62);
  endtask

  task automatic test_random();
    repeat (400) send_random($urandom_range(0, 9) == 0);
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    repeat (20) send_random(1'b0);
  endtask

  task automatic test_quiet();
    quiet = 1'b1;
    repeat (60) send_random(1'b0);
  endtask

  initial begin
    int unsigned drain;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_random();
    test_backpressure();
    test_quiet();
    in_valid_i <= 1'b0;
    drain = 0;
    while (char_queue.size() != 0 && drain < 200000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (200) @(negedge clk_i);
    if (error_count == 0 && char_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
